[sv/decision_forest_vote_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the forest vote block
// Shared property wrappers used by the checker.
// ---------------------------------------------------------------------------
`ifndef DECISION_FOREST_VOTE_MACROS_SVH
`define DECISION_FOREST_VOTE_MACROS_SVH

// implication checked every edge outside reset
`define DFV_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// next-cycle implication outside reset
`define DFV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

[sv/dfv_pkg.sv]
// ---------------------------------------------------------------------------
// dfv_pkg
// Sizes, codes and types shared by the forest vote block.
// ---------------------------------------------------------------------------
package dfv_pkg;

   localparam int TREES          = 16;
   localparam int NODES_PER_TREE = 256;
   localparam int CLASSES        = 32;
   localparam int FEATURES       = 1024;
   localparam int MAX_DEPTH      = 16;

   localparam int TREE_W  = $clog2(TREES);
   localparam int NODE_W  = $clog2(NODES_PER_TREE);
   localparam int CLASS_W = $clog2(CLASSES);
   localparam int FEAT_W  = $clog2(FEATURES);
   localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
   localparam int NADDR_W = TREE_W + NODE_W;
   localparam int PADDR_W = NADDR_W + CLASS_W;
   localparam int SCORE_W = 40;

   typedef enum logic [1:0] {
      MODE_NODE  = 2'd0,
      MODE_PROB  = 2'd1,
      MODE_FEAT  = 2'd2,
      MODE_EVAL  = 2'd3
   } mode_type;

   localparam logic CSR_TREES   = 1'b0;
   localparam logic CSR_CLASSES = 1'b1;

   typedef struct packed {
      logic [1:0]  mode;
      logic [3:0]  tree_sel;
      logic [7:0]  node_sel;
      logic        node_is_leaf;
      logic [9:0]  feature_sel;
      logic [31:0] value;
      logic [7:0]  left_child;
      logic [7:0]  right_child;
      logic [4:0]  class_sel;
      logic        last_frame;
   } req_type;

   typedef struct packed {
      logic [5:0]  predicted_class;
      logic [39:0] best_score;
      logic        walk_error;
   } rsp_type;

   typedef struct packed {
      logic [0:0] index;
      logic [5:0] data;
   } csr_type;

   typedef struct packed {
      logic               leaf;
      logic [FEAT_W-1:0]  feat;
      logic signed [31:0] thr;
      logic [7:0]         lchild;
      logic [7:0]         rchild;
   } node_type;

endpackage

[sv/dfv_if.sv]
// ---------------------------------------------------------------------------
// dfv_if
// Valid/ready channel carrying one word of a given payload type.
// ---------------------------------------------------------------------------
interface dfv_req_if;
   import dfv_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface dfv_rsp_if;
   import dfv_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface dfv_csr_if;
   import dfv_pkg::*;
   logic    valid;
   logic    ready;
   csr_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[sv/decision_forest_vote.sv]
// Steps: an evaluate visits each active tree, reads and tests each inner node, and at
//   the leaf reads and adds the score of each class; a last frame adds an argmax pass.
// Flow: one item at a time, as requests are taken only in idle; a frame's walk is
//   paced by the single read port of each memory.
// Reset: synchronous, active high; sets 16 trees, 32 classes, clears the error flag,
//   then a pass clears the scores with input held off. Tables undefined.
// ---------------------------------------------------------------------------
// decision_forest_vote
// Random-forest engine: table loads, tree walks into per-class scores, argmax.
// ---------------------------------------------------------------------------
module decision_forest_vote
   import dfv_pkg::*;
(
   input logic    clock,
   input logic    reset,
   dfv_req_if.sink   req,
   dfv_rsp_if.source rsp,
   dfv_csr_if.sink   csr
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_TREE, ST_NODE_RD, ST_NODE_EV, ST_FEAT_EV,
      ST_ACC_RD, ST_ACC_WR, ST_MAX_RD, ST_MAX_CMP, ST_OUT
   } state_type;

   // memories
   node_type           node_mem  [TREES*NODES_PER_TREE];
   logic [15:0]        prob_mem  [TREES*NODES_PER_TREE*CLASSES];
   logic signed [31:0] feat_mem  [FEATURES];
   logic [SCORE_W-1:0] score_mem [CLASSES];

   state_type          state_ff;
   logic [4:0]         trees_ff;
   logic [5:0]         classes_ff;
   logic               err_ff;
   logic               last_ff;
   logic [TREE_W:0]    tree_ff, ntree_ff;
   logic [NODE_W-1:0]  node_ff;
   logic [DEPTH_W-1:0] depth_ff;
   logic [CLASS_W:0]   cls_ff, ncls_ff;
   logic [CLASS_W-1:0] best_ff;
   logic [SCORE_W-1:0] best_sc_ff;
   logic               zero_ff;
   node_type           node_rd_ff;
   logic signed [31:0] feat_rd_ff;
   logic [15:0]        prob_rd_ff;
   logic [SCORE_W-1:0] score_rd_ff;
   rsp_type            rsp_ff;
   logic               rsp_valid_ff;

   logic [NADDR_W-1:0] naddr;
   logic [SCORE_W:0]   sum;
   logic [7:0]         next_node;
   logic               go_left;

   assign req.ready = (state_ff == ST_IDLE);
   assign csr.ready = 1'b1;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_ff;

   assign naddr     = {tree_ff[TREE_W-1:0], node_ff};
   assign go_left   = (zero_ff ? 32'sd0 : feat_rd_ff) < node_rd_ff.thr;
   assign next_node = go_left ? node_rd_ff.lchild : node_rd_ff.rchild;
   assign sum       = {1'b0, score_rd_ff} + {{(SCORE_W-16+1){1'b0}}, prob_rd_ff};

   // table writes from the request channel
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         case (req.data.mode)
            MODE_NODE: node_mem[{req.data.tree_sel[TREE_W-1:0], req.data.node_sel}] <=
               '{req.data.node_is_leaf, req.data.feature_sel, req.data.value,
                 req.data.left_child, req.data.right_child};
            MODE_PROB: prob_mem[{req.data.tree_sel[TREE_W-1:0], req.data.node_sel,
               req.data.class_sel}] <= req.data.value[15:0];
            MODE_FEAT: feat_mem[req.data.feature_sel] <= req.data.value;
            default: ;
         endcase
      end
   end

   // synchronous reads
   always_ff @(posedge clock) begin
      node_rd_ff  <= node_mem[naddr];
      feat_rd_ff  <= feat_mem[node_rd_ff.feat];
      prob_rd_ff  <= prob_mem[{naddr, cls_ff[CLASS_W-1:0]}];
      score_rd_ff <= score_mem[cls_ff[CLASS_W-1:0]];
   end

   // score accumulate / clear
   always_ff @(posedge clock) begin
      if (state_ff == ST_ACC_WR)
         score_mem[cls_ff[CLASS_W-1:0]] <= sum[SCORE_W] ? '1 : sum[SCORE_W-1:0];
      else if (state_ff == ST_MAX_CMP || (state_ff == ST_IDLE && reset))
         score_mem[cls_ff[CLASS_W-1:0]] <= '0;
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_MAX_CMP;
         trees_ff     <= 5'd16;
         classes_ff   <= 6'd32;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cls_ff       <= '0;
         ncls_ff      <= (CLASS_W+1)'(CLASSES);
         last_ff      <= 1'b0;
         best_ff      <= '0;
         best_sc_ff   <= '0;
      end else begin
         if (csr.valid) begin
            if (csr.data.index == CSR_TREES) trees_ff <= csr.data.data[4:0];
            else                             classes_ff <= csr.data.data;
         end
         // result word: loaded in ST_OUT once the previous word has left
         if (state_ff == ST_OUT && (!rsp_valid_ff || rsp.ready)) rsp_valid_ff <= 1'b1;
         else if (rsp_valid_ff && rsp.ready)                       rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (req.valid && req.ready && req.data.mode == MODE_EVAL) begin
                  last_ff  <= req.data.last_frame;
                  tree_ff  <= '0;
                  ntree_ff <= (trees_ff > 5'(TREES)) ? (TREE_W+1)'(TREES)
                                                    : (TREE_W+1)'(trees_ff);
                  ncls_ff  <= (classes_ff > 6'(CLASSES)) ? (CLASS_W+1)'(CLASSES) :
                              (classes_ff == 6'd0) ? (CLASS_W+1)'(1)
                                                   : (CLASS_W+1)'(classes_ff);
                  state_ff <= ST_TREE;
               end
            end
            ST_TREE: begin
               node_ff  <= '0;
               depth_ff <= '0;
               cls_ff   <= '0;
               state_ff <= (tree_ff == ntree_ff) ? ST_MAX_RD : ST_NODE_RD;
            end
            ST_NODE_RD: state_ff <= ST_NODE_EV;
            ST_NODE_EV: begin
               if (node_rd_ff.leaf) state_ff <= ST_ACC_RD;
               else if (depth_ff >= DEPTH_W'(MAX_DEPTH)) begin
                  err_ff <= 1'b1;
                  tree_ff <= tree_ff + 1'b1;
                  state_ff <= ST_TREE;
               end else begin
                  zero_ff  <= ({1'b0, node_rd_ff.feat} >= (FEAT_W+1)'(FEATURES));
                  state_ff <= ST_FEAT_EV;
               end
            end
            ST_FEAT_EV: begin
               if (9'(next_node) >= 9'(NODES_PER_TREE)) begin
                  err_ff <= 1'b1;
                  tree_ff <= tree_ff + 1'b1;
                  state_ff <= ST_TREE;
               end else begin
                  node_ff  <= next_node[NODE_W-1:0];
                  depth_ff <= depth_ff + 1'b1;
                  state_ff <= ST_NODE_RD;
               end
            end
            ST_ACC_RD: state_ff <= ST_ACC_WR;
            ST_ACC_WR: begin
               if (cls_ff + 1'b1 == ncls_ff) begin
                  tree_ff  <= tree_ff + 1'b1;
                  state_ff <= ST_TREE;
               end else begin
                  cls_ff   <= cls_ff + 1'b1;
                  state_ff <= ST_ACC_RD;
               end
            end
            ST_MAX_RD: begin
               // non-last frame ends here; the clearing pass after reset goes on
               if (!last_ff && cls_ff == '0) state_ff <= ST_IDLE;
               else state_ff <= ST_MAX_CMP;
            end
            ST_MAX_CMP: begin
               // score read of cls_ff is ready; track winner among used classes
               if (last_ff && cls_ff < ncls_ff &&
                   (cls_ff == '0 || score_rd_ff > best_sc_ff)) begin
                  best_ff    <= cls_ff[CLASS_W-1:0];
                  best_sc_ff <= score_rd_ff;
               end
               if (cls_ff + 1'b1 >= (CLASS_W+1)'(CLASSES)) begin
                  cls_ff   <= '0;
                  state_ff <= last_ff ? ST_OUT : ST_IDLE;
               end else begin
                  cls_ff   <= cls_ff + 1'b1;
                  state_ff <= ST_MAX_RD;
               end
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_ff.predicted_class <= 6'(best_ff) + 6'd1;
                  rsp_ff.best_score      <= best_sc_ff;
                  rsp_ff.walk_error      <= err_ff;
                  err_ff                 <= 1'b0;
                  last_ff                <= 1'b0;
                  state_ff               <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

[sv/dfv_checker.sv]
// ---------------------------------------------------------------------------
// dfv_checker
// Port-level checks on the forest vote block, bound to the top level.
// ---------------------------------------------------------------------------
`include "decision_forest_vote_macros.svh"

module dfv_checker
   import dfv_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [1:0]  req_mode,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [5:0]  rsp_class,
   input logic [39:0] rsp_score
);

   `DFV_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_score) && $stable(rsp_class))
   `DFV_ASSERT_IMPL(a_class_range, clock, reset, rsp_valid, rsp_class != 6'd0)
   `DFV_ASSERT_IMPL(a_class_max, clock, reset, rsp_valid, rsp_class <= 6'd32)
   `DFV_ASSERT_NEXT(a_busy_after, clock, reset, req_valid && req_ready && req_mode == MODE_EVAL, !req_ready)

endmodule

bind decision_forest_vote dfv_checker u_dfv_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req.valid),
   .req_ready (req.ready),
   .req_mode  (req.data.mode),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .rsp_class (rsp.data.predicted_class),
   .rsp_score (rsp.data.best_score)
);

[test/decision_forest_vote_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// decision_forest_vote_tb
// Loads random forests through the write modes and runs frame votes against
// the block. A scoreboard model predicts each vote and compares every field
// of every result word. Before each evaluate, the tree walk is traced first,
// and any node, probability or feature it would touch that was never loaded
// gets written, so no walk ever reads an unloaded entry.
// ---------------------------------------------------------------------------
module decision_forest_vote_tb;
   import dfv_pkg::*;

   localparam int DRAIN_CYCLES = 2500;   // worst evaluate with no result word

   typedef struct {
      bit               leaf;
      bit [9:0]         feat;
      bit signed [31:0] thr;
      bit [7:0]         lchild;
      bit [7:0]         rchild;
   } fnode_type;

   typedef enum int {GAP_NONE, GAP_NODE, GAP_PROB, GAP_FEAT} gap_kind_type;

   logic clock = 1'b0;
   logic reset;

   dfv_req_if req ();
   dfv_rsp_if rsp ();
   dfv_csr_if csr ();

   decision_forest_vote DUT (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source),
      .csr   (csr.sink)
   );

   // forest image, with a loaded flag per entry
   fnode_type        forest_nodes [TREES*NODES_PER_TREE];
   bit               node_loaded  [TREES*NODES_PER_TREE];
   bit [15:0]        leaf_probs   [TREES*NODES_PER_TREE*CLASSES];
   bit               prob_loaded  [TREES*NODES_PER_TREE*CLASSES];
   bit signed [31:0] frame_feats  [FEATURES];
   bit               feat_loaded  [FEATURES];
   bit [39:0]        video_scores [CLASSES];
   bit               walk_err_seen;
   bit [4:0]         cfg_trees;
   bit [5:0]         cfg_classes;

   rsp_type vote_q [$];
   int      fails;
   int      send_gap_pct;
   int      stall_pct;
   int      hold_cycles;
   int      sent_words;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // forest model
   // ------------------------------------------------------------------
   function automatic int used_trees();
      return (cfg_trees > TREES) ? TREES : int'(cfg_trees);
   endfunction

   function automatic int used_classes();
      if (cfg_classes == 0) return 1;
      return (cfg_classes > CLASSES) ? CLASSES : int'(cfg_classes);
   endfunction

   // Walk one tree. With commit clear it only looks for an unloaded entry;
   // with commit set it adds the leaf into the video scores or flags a depth-limit error.
   function automatic gap_kind_type walk_forest_tree(int t, bit commit, output int addr);
      int node;
      int depth;
      int n;
      int pa;
      int fi;
      bit [40:0] sum;
      node = 0;
      depth = 0;
      addr = 0;
      forever begin
         n = t * NODES_PER_TREE + node;
         if (!node_loaded[n]) begin
            addr = n;
            return GAP_NODE;
         end
         if (forest_nodes[n].leaf) begin
            for (int c = 0; c < used_classes(); c++) begin
               pa = n * CLASSES + c;
               if (!prob_loaded[pa]) begin
                  addr = pa;
                  return GAP_PROB;
               end
               if (commit) begin
                  sum = video_scores[c] + leaf_probs[pa];
                  video_scores[c] = sum[40] ? 40'hFF_FFFF_FFFF : sum[39:0];
               end
            end
            return GAP_NONE;
         end
         if (depth >= MAX_DEPTH) begin
            if (commit) walk_err_seen = 1'b1;
            return GAP_NONE;
         end
         fi = forest_nodes[n].feat;
         if (!feat_loaded[fi]) begin
            addr = fi;
            return GAP_FEAT;
         end
         node = (frame_feats[fi] < forest_nodes[n].thr) ? forest_nodes[n].lchild
                                                        : forest_nodes[n].rchild;
         depth++;
      end
   endfunction

   // update the model for one accepted word
   function automatic void model_word(req_type w);
      int n;
      int a;
      int best;
      rsp_type vote;
      n = w.tree_sel * NODES_PER_TREE + w.node_sel;
      case (w.mode)
         MODE_NODE: begin
            forest_nodes[n].leaf   = w.node_is_leaf;
            forest_nodes[n].feat   = w.feature_sel;
            forest_nodes[n].thr    = w.value;
            forest_nodes[n].lchild = w.left_child;
            forest_nodes[n].rchild = w.right_child;
            node_loaded[n] = 1'b1;
         end
         MODE_PROB: begin
            leaf_probs[n * CLASSES + w.class_sel]  = w.value[15:0];
            prob_loaded[n * CLASSES + w.class_sel] = 1'b1;
         end
         MODE_FEAT: begin
            frame_feats[w.feature_sel] = w.value;
            feat_loaded[w.feature_sel] = 1'b1;
         end
         default: begin
            for (int t = 0; t < used_trees(); t++)
               void'(walk_forest_tree(t, 1'b1, a));
            if (w.last_frame) begin
               best = 0;
               for (int c = 1; c < used_classes(); c++)
                  if (video_scores[c] > video_scores[best]) best = c;
               vote.predicted_class = 6'(best + 1);
               vote.best_score      = video_scores[best];
               vote.walk_error      = walk_err_seen;
               vote_q.push_back(vote);
               foreach (video_scores[c]) video_scores[c] = '0;
               walk_err_seen = 1'b0;
            end
         end
      endcase
   endfunction

   // ------------------------------------------------------------------
   // drivers
   // ------------------------------------------------------------------
   task automatic send_word(req_type w);
      if ($urandom_range(99) < send_gap_pct) begin
         req.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_gap_pct);
      end
      req.valid <= 1'b1;
      req.data  <= w;
      do @(posedge clock); while (!req.ready);
      model_word(w);
      sent_words++;
   endtask

   task automatic write_csr(logic idx, bit [5:0] val);
      req.valid  <= 1'b0;
      csr.valid  <= 1'b1;
      csr.data.index <= idx;
      csr.data.data  <= val;
      do @(posedge clock); while (!csr.ready);
      csr.valid <= 1'b0;
      if (idx == CSR_TREES) cfg_trees = val[4:0];
      else                  cfg_classes = val;
      @(posedge clock);
   endtask

   // wait for all votes, then for any evaluate still walking
   task automatic drain();
      req.valid <= 1'b0;
      while (vote_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic req_type noise_word();
      bit [95:0] raw;
      req_type w;
      raw = {$urandom, $urandom, $urandom};
      w = raw[$bits(req_type)-1:0];
      w.mode = mode_type'($urandom_range(0, 2));
      return w;
   endfunction

   function automatic req_type write_word(mode_type m, int t, int nd);
      req_type w;
      w = noise_word();
      w.mode     = m;
      w.tree_sel = 4'(t);
      w.node_sel = 8'(nd);
      return w;
   endfunction

   // load whatever the coming walk would find missing, then evaluate
   task automatic eval_frame(bit last);
      gap_kind_type k;
      int a;
      req_type w;
      forever begin
         k = GAP_NONE;
         for (int t = 0; t < used_trees() && k == GAP_NONE; t++)
            k = walk_forest_tree(t, 1'b0, a);
         if (k == GAP_NONE) break;
         case (k)
            GAP_NODE: begin
               w = write_word(MODE_NODE, a / NODES_PER_TREE, a % NODES_PER_TREE);
               w.node_is_leaf = ($urandom_range(99) < 40);
               if ($urandom_range(1)) w.feature_sel = 10'($urandom_range(0, 15));
               if ($urandom_range(3) != 0) begin
                  w.left_child  = 8'($urandom_range(0, 15));
                  w.right_child = 8'($urandom_range(0, 15));
               end
            end
            GAP_PROB: begin
               w = write_word(MODE_PROB, a / (NODES_PER_TREE*CLASSES),
                              (a / CLASSES) % NODES_PER_TREE);
               w.class_sel = 5'(a % CLASSES);
            end
            default: begin
               w = write_word(MODE_FEAT, 0, 0);
               w.feature_sel = 10'(a);
            end
         endcase
         send_word(w);
      end
      w = noise_word();
      w.mode = MODE_EVAL;
      w.last_frame = last;
      send_word(w);
   endtask

   // ------------------------------------------------------------------
   // receiver and result check
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         rsp.ready <= 1'b0;
         hold_cycles = hold_cycles - 1;
      end else begin
         rsp.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type exp_vote;
      if (!reset && rsp.valid && rsp.ready) begin
         if (vote_q.size() == 0) begin
            $error("unexpected vote word: class %0d score %0d",
                   rsp.data.predicted_class, rsp.data.best_score);
            fails++;
         end else begin
            exp_vote = vote_q.pop_front();
            if (rsp.data.predicted_class !== exp_vote.predicted_class) begin
               $error("predicted_class: expected %0d, got %0d",
                      exp_vote.predicted_class, rsp.data.predicted_class);
               fails++;
            end
            if (rsp.data.best_score !== exp_vote.best_score) begin
               $error("best_score: expected %0d, got %0d",
                      exp_vote.best_score, rsp.data.best_score);
               fails++;
            end
            if (rsp.data.walk_error !== exp_vote.walk_error) begin
               $error("walk_error: expected %0d, got %0d",
                      exp_vote.walk_error, rsp.data.walk_error);
               fails++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------
   // Hand-built forest: extreme thresholds and features, a class tie,
   // a tree that loops until the depth limit.
   task automatic test_directed();
      req_type w;
      write_csr(CSR_TREES, 6'd2);
      write_csr(CSR_CLASSES, 6'd4);
      w = write_word(MODE_NODE, 0, 0);
      w.node_is_leaf = 1'b0; w.feature_sel = 10'd1023; w.value = 32'h8000_0000;
      w.left_child = 8'd1; w.right_child = 8'd255;
      send_word(w);
      w = write_word(MODE_NODE, 0, 255);
      w.node_is_leaf = 1'b1;
      send_word(w);
      w = write_word(MODE_NODE, 1, 0);
      w.node_is_leaf = 1'b0; w.feature_sel = 10'd0; w.value = 32'h7FFF_FFFF;
      w.left_child = 8'd0; w.right_child = 8'd0;
      send_word(w);
      for (int c = 0; c < 4; c++) begin
         w = write_word(MODE_PROB, 0, 255);
         w.class_sel = 5'(c);
         w.value = (c < 2) ? 32'hFFFF_FFFF : 32'h0000_0001;
         send_word(w);
      end
      w = write_word(MODE_FEAT, 0, 0);
      w.feature_sel = 10'd1023; w.value = 32'h8000_0000;
      send_word(w);
      w = write_word(MODE_FEAT, 0, 0);
      w.feature_sel = 10'd0; w.value = 32'h7FFF_FFFF;
      send_word(w);
      eval_frame(1'b0);
      eval_frame(1'b1);
      // last_frame on a write word does nothing
      w = write_word(MODE_FEAT, 0, 0);
      w.feature_sel = 10'd0; w.value = 32'h0; w.last_frame = 1'b1;
      send_word(w);
      eval_frame(1'b1);
      drain();
      // no trees at all, and zero classes acting as one
      write_csr(CSR_TREES, 6'd0);
      write_csr(CSR_CLASSES, 6'd0);
      eval_frame(1'b1);
      drain();
   endtask

   // runs videos and noise writes until about budget words have been sent
   task automatic run_phase(int trees, int classes, int gap, int stall, int budget);
      int frames;
      int start;
      send_gap_pct = gap;
      stall_pct = stall;
      write_csr(CSR_TREES, 6'(trees));
      write_csr(CSR_CLASSES, 6'(classes));
      start = sent_words;
      while (sent_words - start < budget) begin
         if ($urandom_range(99) < 70) begin
            // one video: a few feature updates between frames
            frames = $urandom_range(1, 4);
            for (int f = 0; f < frames; f++) begin
               repeat ($urandom_range(0, 3)) begin
                  req_type w;
                  w = write_word(MODE_FEAT, 0, 0);
                  if ($urandom_range(1)) w.feature_sel = 10'($urandom_range(0, 15));
                  send_word(w);
               end
               eval_frame(f == frames - 1);
            end
         end else begin
            send_word(noise_word());
         end
      end
      drain();
   endtask

   task automatic test_random_phases();
      run_phase(4, 8, 0, 0, 100);
      run_phase(1, 33, 69, 0, 100);
      run_phase(17, 3, 0, 69, 100);
      run_phase(3, 12, 20, 20, 100);
      run_phase($urandom_range(0, 6), $urandom_range(0, 12), 20, 20, 100);
      run_phase($urandom_range(1, 8), $urandom_range(1, 16), 0, 0, 100);
   endtask

   // receiver holds off while votes keep coming, filling the block
   task automatic test_backpressure();
      send_gap_pct = 0;
      stall_pct = 0;
      write_csr(CSR_TREES, 6'd4);
      write_csr(CSR_CLASSES, 6'd8);
      hold_cycles = 6000;
      repeat (12) eval_frame(1'b1);
      drain();
   endtask

   initial begin
      req.valid = 1'b0;
      req.data  = '0;
      csr.valid = 1'b0;
      csr.data  = '0;
      rsp.ready = 1'b0;
      fails = 0;
      hold_cycles = 0;
      send_gap_pct = 0;
      stall_pct = 0;
      sent_words = 0;
      cfg_trees = 5'd16;
      cfg_classes = 6'd32;
      walk_err_seen = 1'b0;
      foreach (video_scores[c]) video_scores[c] = '0;
      reset = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      // wait out the score clearing pass
      do @(posedge clock); while (!req.ready);
      test_directed();
      test_random_phases();
      test_backpressure();
      if (fails == 0)
         $display("decision_forest_vote_tb: clean");
      else
         $display("decision_forest_vote_tb: errors");
      $finish;
   end

   initial begin
      #60ms;
      $display("decision_forest_vote_tb: errors");
      $finish;
   end

endmodule
